>>> src/encoder_pid_speed_hbridge_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the encoder PID speed controller
// ---------------------------------------------------------------------------
`ifndef ENCODER_PID_SPEED_HBRIDGE_ASSERT_SVH
`define ENCODER_PID_SPEED_HBRIDGE_ASSERT_SVH

// condition implies consequence in the same cycle
`define EPH_ASSERT_IMP(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define EPH_ASSERT_NXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/encpid_pkg.sv
// ---------------------------------------------------------------------------
// encpid_pkg
// Shared types and constants of the encoder PID speed controller.
// ---------------------------------------------------------------------------
package encpid_pkg;

   localparam int DUTY_BITS_DEF = 13;
   localparam int FRAC_BITS_DEF = 16;

   localparam int TIME_W  = 32;
   localparam int POS_W   = 32;
   localparam int SPEED_W = 24;
   localparam int CMD_W   = 3;
   localparam int DIR_W   = 2;
   localparam int REQ_W   = 64;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 31;

   localparam logic [SPEED_W-2:0] SPEED_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ACT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEACT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ENCRST = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SETDIR = 3'd5;

   localparam logic [DIR_W-1:0] MODE_FWD   = 2'd0;
   localparam logic [DIR_W-1:0] MODE_REV   = 2'd1;
   localparam logic [DIR_W-1:0] MODE_BRAKE = 2'd2;
   localparam logic [DIR_W-1:0] MODE_STOP  = 2'd3;

   localparam logic [CSR_AW-1:0] REG_KP    = 3'd0;
   localparam logic [CSR_AW-1:0] REG_KI    = 3'd1;
   localparam logic [CSR_AW-1:0] REG_KD    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_ILIM  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_CPM   = 3'd4;
   localparam logic [CSR_AW-1:0] REG_MINUP = 3'd5;
   localparam logic [CSR_AW-1:0] REG_STALL = 3'd6;
   localparam logic [CSR_AW-1:0] REG_EN    = 3'd7;

   localparam logic [15:0] KP_RST    = 16'd3000;
   localparam logic [15:0] KI_RST    = 16'd40;
   localparam logic [19:0] KD_RST    = 20'd500000;
   localparam logic [30:0] ILIM_RST  = 31'd131072000;
   localparam logic [15:0] CPM_RST   = 16'd345;
   localparam logic [19:0] MINUP_RST = 20'd500;
   localparam logic [23:0] STALL_RST = 24'd200000;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic                     chan_a;
      logic                     chan_b;
      logic [TIME_W-1:0]        time_us;
      logic signed [SPEED_W-1:0] target;
      logic [DIR_W-1:0]         dir;
   } item_type;

endpackage

>>> src/encpid_front.sv
// ---------------------------------------------------------------------------
// encpid_front
// Accepts request words, unpacks them and queues them for the engine.
// ---------------------------------------------------------------------------
module encpid_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [encpid_pkg::REQ_W-1:0]   req_tdata,  // chan_a, chan_b, time_us, target, dir
   input  logic [encpid_pkg::CMD_W-1:0]   req_tuser,  // cmd
   output logic                           item_valid,
   input  logic                           item_pop,
   output encpid_pkg::item_type           item
);
   import encpid_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   item_type   word;

   always_comb begin
      word.cmd     = req_tuser;
      word.chan_a  = req_tdata[0];
      word.chan_b  = req_tdata[1];
      word.time_us = req_tdata[33:2];
      word.target  = $signed(req_tdata[57:34]);
      word.dir     = req_tdata[59:58];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

>>> src/encpid_div.sv
// ---------------------------------------------------------------------------
// encpid_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module encpid_div #(
   parameter int DVD_W = 68,
   parameter int DVS_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/encpid_back.sv
// ---------------------------------------------------------------------------
// encpid_back
// Command engine: encoder count, speed estimate, PID and bridge drive.
// ---------------------------------------------------------------------------
module encpid_back #(
   parameter int DUTY_BITS = encpid_pkg::DUTY_BITS_DEF,
   parameter int FRAC_BITS = encpid_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_pop,
   input  encpid_pkg::item_type            item,
   input  logic                            csr_we,
   input  logic [encpid_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [encpid_pkg::CSR_DW-1:0]   csr_wdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((3*DUTY_BITS+57+7)/8)*8-1:0] rsp_tdata
);
   import encpid_pkg::*;
`include "encoder_pid_speed_hbridge_assert.svh"

   localparam int RSP_W  = ((3*DUTY_BITS+57+7)/8)*8;
   localparam int DVD_W  = 52 + FRAC_BITS;
   localparam int DVS_W  = 48;
   localparam int CORR_W = DVD_W + 3;
   localparam int ISUM_W = DVD_W + 2;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
   // floor(2^36 / 1000); estimate is exact or one low for 26-bit numerators
   localparam logic [26:0] RECIP_1000 = 27'd68719476;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EMUL  = 4'd1;
   localparam logic [3:0] S_EDIV  = 4'd2;
   localparam logic [3:0] S_EWAIT = 4'd3;
   localparam logic [3:0] S_PID0  = 4'd4;
   localparam logic [3:0] S_PID1  = 4'd5;
   localparam logic [3:0] S_PID2  = 4'd6;
   localparam logic [3:0] S_PID3  = 4'd7;
   localparam logic [3:0] S_PID4  = 4'd8;
   localparam logic [3:0] S_PID5  = 4'd9;
   localparam logic [3:0] S_PID6  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_IACC  = 4'd12;

   logic [3:0]  state_ff, state_in;

   logic [15:0] kp_ff, kp_in, ki_ff, ki_in, cpm_ff, cpm_in;
   logic [19:0] kd_ff, kd_in, minup_ff, minup_in;
   logic [30:0] ilim_ff, ilim_in;
   logic [23:0] stall_ff, stall_in;
   logic        en_ff, en_in;

   logic [31:0] pos_ff, pos_in, lpos_ff, lpos_in, lst_ff, lst_in, lct_ff, lct_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [31:0]        integ_ff, integ_in;
   logic signed [24:0]        prev_ff, prev_in;
   logic [DIR_W-1:0]          mode_ff, mode_in;
   logic                      active_ff, active_in;
   logic signed [DUTY_BITS:0] drive_ff, drive_in;
   logic [DUTY_BITS-1:0]      duty_a_ff, duty_a_in, duty_b_ff, duty_b_in;

   item_type    item_ff, item_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic [51:0] num_ff, num_in;
   logic [47:0] den_ff, den_in;
   logic signed [24:0] e_ff, e_in;
   logic signed [25:0] ediff_ff, ediff_in;
   logic [31:0] cdt_ff, cdt_in;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [46:0] kde_ff, kde_in;
   logic signed [56:0] kdk_ff, kdk_in;
   logic signed [41:0] kpe_ff, kpe_in;
   logic signed [48:0] kie_ff, kie_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;

   // divide by 1000, 16 bits per step
   logic [63:0] dq_ff, dq_in;
   logic [9:0]  drem_ff, drem_in;
   logic [15:0] qe_ff, qe_in;
   logic        dph_ff, dph_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [25:0] dn, dr;
   logic [52:0] dprod;
   logic [15:0] dq16;
   logic signed [64:0] sk;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              div_start, div_done;
   logic [DVD_W-1:0]  div_dvd, div_q;
   logic [DVS_W-1:0]  div_dvs;

   logic [31:0] d_w, dt_w, dt_eff, lct_eff;
   logic [15:0] cpm_eff;
   logic [22:0] sval;
   logic signed [24:0] e_w;
   logic [31:0] cdt_w;
   logic [57:0] prod_mag;
   logic [56:0] kdk_mag;
   logic signed [DVD_W:0]    sq;
   logic signed [ISUM_W-1:0] isum, lim_p;
   logic signed [CORR_W-1:0] corr_c, corr_sh, mx_c;
   logic signed [DUTY_BITS:0] vdrv;
   logic [DIR_W-1:0]          amode;
   logic                      apply;
   logic [DUTY_BITS-1:0]      vmag;
   logic                      out_load;

   encpid_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // config registers
   always_comb begin
      kp_in = kp_ff; ki_in = ki_ff; kd_in = kd_ff; ilim_in = ilim_ff;
      cpm_in = cpm_ff; minup_in = minup_ff; stall_in = stall_ff; en_in = en_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_KP:    kp_in    = csr_wdata[15:0];
            REG_KI:    ki_in    = csr_wdata[15:0];
            REG_KD:    kd_in    = csr_wdata[19:0];
            REG_ILIM:  ilim_in  = csr_wdata[30:0];
            REG_CPM:   cpm_in   = csr_wdata[15:0];
            REG_MINUP: minup_in = csr_wdata[19:0];
            REG_STALL: stall_in = csr_wdata[23:0];
            REG_EN:    en_in    = csr_wdata[0];
            default:   en_in    = en_ff;
         endcase
      end
   end

   assign div_start = (state_ff == S_EDIV) || (state_ff == S_PID4);
   always_comb begin
      prod_mag = prod_ff[57] ? 58'(-prod_ff) : 58'(prod_ff);
      kdk_mag  = kdk_ff[56] ? 57'(-kdk_ff) : 57'(kdk_ff);
      priority case (state_ff)
         S_EDIV: begin
            div_dvd = {num_ff, FRAC_BITS'(0)};
            div_dvs = den_ff;
         end
         default: begin
            div_dvd = DVD_W'(kdk_mag);
            div_dvs = 48'(cdt_ff);
         end
      endcase
   end

   // drive application
   always_comb begin
      vmag = vdrv[DUTY_BITS] ? DUTY_BITS'(-vdrv) : DUTY_BITS'(vdrv);
      duty_a_in = duty_a_ff;
      duty_b_in = duty_b_ff;
      drive_in  = drive_ff;
      if (apply) begin
         unique case (amode)
            MODE_STOP: begin
               duty_a_in = '0; duty_b_in = '0; drive_in = '0;
            end
            MODE_BRAKE: begin
               duty_a_in = DUTY_MAX; duty_b_in = DUTY_MAX; drive_in = '0;
            end
            default: begin
               drive_in = vdrv;
               if ((amode == MODE_REV) == vdrv[DUTY_BITS]) begin
                  duty_a_in = vmag; duty_b_in = '0;
               end else begin
                  duty_a_in = '0; duty_b_in = vmag;
               end
            end
         endcase
      end
   end

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      item_in = item_ff; neg_in = neg_ff; mag_in = mag_ff; num_in = num_ff;
      den_in = den_ff; e_in = e_ff; ediff_in = ediff_ff; cdt_in = cdt_ff;
      prod_in = prod_ff; kde_in = kde_ff; kdk_in = kdk_ff; kpe_in = kpe_ff;
      kie_in = kie_ff; corr_in = corr_ff;
      dq_in = dq_ff; drem_in = drem_ff; qe_in = qe_ff; dph_in = dph_ff; dcnt_in = dcnt_ff;
      pos_in = pos_ff; lpos_in = lpos_ff; lst_in = lst_ff; lct_in = lct_ff;
      speed_in = speed_ff; integ_in = integ_ff; prev_in = prev_ff;
      mode_in = mode_ff; active_in = active_ff;
      apply = 1'b0; amode = mode_ff; vdrv = '0;
      d_w = pos_ff - lpos_ff;
      dt_w = item.time_us - lst_ff;
      dt_eff = (dt_w == 32'd0) ? 32'd1 : dt_w;
      cpm_eff = (cpm_ff == 16'd0) ? 16'd1 : cpm_ff;
      lct_eff = (lct_ff == 32'd0) ? item.time_us : lct_ff;
      sval = (div_q > DVD_W'(SPEED_MAX)) ? SPEED_MAX : div_q[22:0];
      e_w = 25'(item_ff.target) - 25'(speed_ff);
      cdt_w = item_ff.time_us - lct_ff;
      sq = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      dn = {drem_ff, dq_ff[63:48]};
      dprod = 53'(dn) * 53'(RECIP_1000);
      dr = dn - 26'(qe_ff) * 26'd1000;
      dq16 = (dr >= 26'd1000) ? qe_ff + 16'd1 : qe_ff;
      sk = neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      isum = ISUM_W'(integ_ff) + ISUM_W'(sk);
      lim_p = ISUM_W'($signed({1'b0, ilim_ff}));
      corr_c = corr_ff;
      if ((corr_ff > 0 && item_ff.target < 0) || (corr_ff < 0 && item_ff.target > 0)) begin
         corr_c = '0;
      end
      corr_sh = corr_c[CORR_W-1] ? -((-corr_c) >>> FRAC_BITS) : (corr_c >>> FRAC_BITS);
      mx_c = CORR_W'($signed({1'b0, DUTY_MAX}));
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               state_in = S_OUT;
               unique case (item.cmd)
                  CMD_TICK: begin
                     lct_in = lct_eff;
                     if (d_w != 32'd0 && dt_w >= 32'(minup_ff)) begin
                        neg_in   = d_w[31];
                        mag_in   = d_w[31] ? -d_w : d_w;
                        den_in   = cpm_eff * dt_eff;
                        state_in = S_EMUL;
                     end else begin
                        if (dt_w >= 32'(stall_ff)) speed_in = '0;
                        state_in = (active_ff && en_ff) ? S_PID0 : S_OUT;
                     end
                  end
                  CMD_EDGE: begin
                     if (item.chan_a) pos_in = item.chan_b ? pos_ff + 32'd1 : pos_ff - 32'd1;
                  end
                  CMD_ACT: begin
                     active_in = 1'b1; mode_in = MODE_FWD; lct_in = item.time_us;
                     integ_in = '0; prev_in = '0;
                  end
                  CMD_DEACT: begin
                     active_in = 1'b0; mode_in = MODE_STOP;
                     apply = 1'b1; amode = MODE_STOP;
                  end
                  CMD_ENCRST: begin
                     pos_in = '0; lpos_in = '0; lst_in = item.time_us; speed_in = '0;
                  end
                  CMD_SETDIR: begin
                     mode_in = item.dir;
                     apply = (item.dir == MODE_BRAKE) || (item.dir == MODE_STOP);
                     amode = item.dir;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_EMUL: begin
            num_in   = 52'(mag_ff) * 52'd1000000;
            state_in = S_EDIV;
         end
         S_EDIV: state_in = S_EWAIT;
         S_EWAIT: begin
            if (div_done) begin
               speed_in = neg_ff ? -$signed({1'b0, sval}) : $signed({1'b0, sval});
               lpos_in  = pos_ff;
               lst_in   = item_ff.time_us;
               state_in = (active_ff && en_ff) ? S_PID0 : S_OUT;
            end
         end
         S_PID0: begin
            e_in     = e_w;
            ediff_in = 26'(e_w) - 26'(prev_ff);
            cdt_in   = (cdt_w == 32'd0) ? 32'd1 : cdt_w;
            lct_in   = item_ff.time_us;
            state_in = S_PID1;
         end
         S_PID1: begin
            prod_in  = 58'(e_ff) * 58'($signed({1'b0, cdt_ff}));
            kde_in   = 47'($signed({1'b0, kd_ff})) * 47'(ediff_ff);
            kpe_in   = 42'($signed({1'b0, kp_ff})) * 42'(e_ff);
            state_in = S_PID2;
         end
         S_PID2: begin
            kdk_in   = 57'(kde_ff) * 57'sd1000;
            neg_in   = prod_ff[57];
            prev_in  = e_ff;
            dq_in    = 64'(prod_mag);
            drem_in  = '0;
            dph_in   = 1'b0;
            dcnt_in  = '0;
            state_in = S_PID3;
         end
         S_PID3: begin
            // quotient estimate, then remainder and one correction
            if (!dph_ff) begin
               qe_in  = dprod[51:36];
               dph_in = 1'b1;
            end else begin
               dq_in   = {dq_ff[47:0], dq16};
               drem_in = (dr >= 26'd1000) ? 10'(dr - 26'd1000) : dr[9:0];
               dph_in  = 1'b0;
               dcnt_in = dcnt_ff + 2'd1;
               if (dcnt_ff == 2'd3) state_in = S_IACC;
            end
         end
         S_IACC: begin
            if (isum > lim_p) integ_in = 32'(lim_p);
            else if (isum < -lim_p) integ_in = 32'(-lim_p);
            else integ_in = 32'(isum);
            state_in = S_PID4;
         end
         S_PID4: begin
            kie_in   = 49'($signed({1'b0, ki_ff})) * 49'(integ_ff);
            neg_in   = kdk_ff[56];
            state_in = S_PID5;
         end
         S_PID5: begin
            if (div_done) begin
               corr_in  = CORR_W'(kpe_ff) + CORR_W'(kie_ff) + CORR_W'(sq);
               state_in = S_PID6;
            end
         end
         S_PID6: begin
            apply = 1'b1;
            if (corr_sh > mx_c) vdrv = $signed({1'b0, DUTY_MAX});
            else if (corr_sh < -mx_c) vdrv = -$signed({1'b0, DUTY_MAX});
            else vdrv = (DUTY_BITS+1)'(corr_sh);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({drive_ff, speed_ff, pos_ff, duty_b_ff, duty_a_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kp_ff <= KP_RST; ki_ff <= KI_RST; kd_ff <= KD_RST; ilim_ff <= ILIM_RST;
         cpm_ff <= CPM_RST; minup_ff <= MINUP_RST; stall_ff <= STALL_RST; en_ff <= 1'b1;
         pos_ff <= '0; lpos_ff <= '0; lst_ff <= '0; lct_ff <= '0;
         speed_ff <= '0; integ_ff <= '0; prev_ff <= '0;
         mode_ff <= MODE_STOP; active_ff <= 1'b0; drive_ff <= '0;
         duty_a_ff <= '0; duty_b_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kp_ff <= kp_in; ki_ff <= ki_in; kd_ff <= kd_in; ilim_ff <= ilim_in;
         cpm_ff <= cpm_in; minup_ff <= minup_in; stall_ff <= stall_in; en_ff <= en_in;
         pos_ff <= pos_in; lpos_ff <= lpos_in; lst_ff <= lst_in; lct_ff <= lct_in;
         speed_ff <= speed_in; integ_ff <= integ_in; prev_ff <= prev_in;
         mode_ff <= mode_in; active_ff <= active_in; drive_ff <= drive_in;
         duty_a_ff <= duty_a_in; duty_b_ff <= duty_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; neg_ff <= neg_in; mag_ff <= mag_in; num_ff <= num_in;
      den_ff <= den_in; e_ff <= e_in; ediff_ff <= ediff_in; cdt_ff <= cdt_in;
      prod_ff <= prod_in; kde_ff <= kde_in; kdk_ff <= kdk_in; kpe_ff <= kpe_in;
      kie_ff <= kie_in; corr_ff <= corr_in;
      dq_ff <= dq_in; drem_ff <= drem_in; qe_ff <= qe_in; dph_ff <= dph_in;
      dcnt_ff <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `EPH_ASSERT_IMP(a_pop_idle, clock, reset, item_pop, state_ff == S_IDLE,
      "item taken outside idle")
   `EPH_ASSERT_IMP(a_stop_off, clock, reset, mode_ff == MODE_STOP,
      duty_a_ff == '0 && duty_b_ff == '0 && drive_ff == '0, "stop mode not off")
   `EPH_ASSERT_IMP(a_brake_on, clock, reset, mode_ff == MODE_BRAKE,
      duty_a_ff == DUTY_MAX && duty_b_ff == DUTY_MAX, "brake mode not full")
   `EPH_ASSERT_IMP(a_div_wait, clock, reset, div_done,
      state_ff == S_EWAIT || state_ff == S_PID5,
      "divider done outside a wait state")
   `EPH_ASSERT_NXT(a_out_load, clock, reset, out_load, rsp_tvalid && state_ff == S_IDLE,
      "result not presented")

endmodule

>>> src/encoder_pid_speed_hbridge.sv
// ---------------------------------------------------------------------------
// encoder_pid_speed_hbridge
// Encoder counter with PID speed loop driving an H-bridge.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries command words (tuser = cmd): tick, encoder edge, activate,
//   deactivate, encoder reset, set direction. Every word gives one rsp word
//   with both duties, the position, the speed estimate and the applied drive.
//   csr_* writes gain, limit, timing and enable registers; write only while idle.
// Sequence: encoder and mode commands pass straight to the output register,
//   as does a tick without estimate or PID. A speed estimate and the PID
//   step each add their own states: the divide by 1000 runs four 16-bit
//   steps, the derivative term waits on the one-bit-per-cycle divider.
// A two-word input queue lets requests land while the engine works, and the
// output register holds a result while the receiver stalls; the engine waits
// on a full output register.
// Reset clears position, speed, PID state, duties and sets stop mode; the
// registers return to their default values.
// ---------------------------------------------------------------------------
module encoder_pid_speed_hbridge #(
   parameter int DUTY_BITS = encpid_pkg::DUTY_BITS_DEF,
   parameter int FRAC_BITS = encpid_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [encpid_pkg::REQ_W-1:0]  req_tdata,  // chan_a, chan_b, time_us, target, dir
   input  logic [encpid_pkg::CMD_W-1:0]  req_tuser,  // cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [((3*DUTY_BITS+57+7)/8)*8-1:0] rsp_tdata, // duty_a, duty_b, position,
                                                          // speed, applied
   input  logic                          csr_we,
   input  logic [encpid_pkg::CSR_AW-1:0] csr_addr,
   input  logic [encpid_pkg::CSR_DW-1:0] csr_wdata
);
   import encpid_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_pop;

   encpid_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   encpid_back #(.DUTY_BITS(DUTY_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
